[rtl/core/tcw_pkg.sv]
// Shared types and constants of the text console writer: field widths,
// opcodes, register indexes, sequencer states and the result record.
// No dependencies.
package tcw_pkg;

  localparam int OPC_W  = 3;
  localparam int CHAR_W = 8;
  localparam int ROW_W  = 5;
  localparam int COL_W  = 7;
  localparam int CLR_W  = 4;
  localparam int OFS_W  = 11;
  localparam int CELL_W = 16;

  // Screen coordinates are window origin plus caret, one bit wider.
  localparam int SCR_ROW_W = ROW_W + 1;
  localparam int SCR_COL_W = COL_W + 1;

  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 32;
  localparam int CFG_ADDR_W = 5;
  localparam int CFG_DATA_W = 32;

  localparam logic [OPC_W-1:0] OP_PUT_CHAR  = 3'd0;
  localparam logic [OPC_W-1:0] OP_SET_CARET = 3'd1;
  localparam logic [OPC_W-1:0] OP_SET_VIS   = 3'd2;
  localparam logic [OPC_W-1:0] OP_CLEAR     = 3'd3;
  localparam logic [OPC_W-1:0] OP_READ_CELL = 3'd4;

  localparam logic [CHAR_W-1:0] CHAR_CR = 8'h0D;
  localparam logic [CHAR_W-1:0] CHAR_LF = 8'h0A;

  localparam logic [2:0] REG_WIN_TOP    = 3'd0;
  localparam logic [2:0] REG_WIN_LEFT   = 3'd1;
  localparam logic [2:0] REG_WIN_HEIGHT = 3'd2;
  localparam logic [2:0] REG_WIN_WIDTH  = 3'd3;
  localparam logic [2:0] REG_FORE       = 3'd4;
  localparam logic [2:0] REG_BACK       = 3'd5;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_COPY,
    ST_FILL,
    ST_DONE
  } tcw_state_t;

  typedef struct packed {
    logic [CLR_W-1:0]  back;
    logic [CLR_W-1:0]  fore;
    logic [CHAR_W-1:0] chr;
    logic [OFS_W-1:0]  cursor;
  } tcw_result_t;

endpackage

[rtl/core/tcw_ram.sv]
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module tcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[rtl/core/text_console_writer_core.sv]
// Text console writer: a ROWS x COLS screen of 16-bit cells (character, foreground,
// background) in one RAM, with a window that scrolls on line feed and can be cleared.
// Depends on tcw_pkg and tcw_ram.
//
// Timing: put char, carriage return, set caret, set visibility and read cell go from
// idle through the done state back to idle. A put char that scrolls the window (a line
// feed or a wrapping byte, caret on or below the last row) goes through the copy state,
// if the window has more than one row, then the fill state; clear window goes through
// the fill state alone, as every cell of the effective window goes through the single
// write port of the screen RAM, one per cycle. After reset the block sweeps the whole
// screen to zero before it takes its first request; configuration writes are taken
// during the sweep. Up to one finished result waits in the output register while the
// next request is taken. A read of a cell still in the write stage is forwarded.
module text_console_writer_core #(
  parameter int ROWS = 25,
  parameter int COLS = 80
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // Input requests.
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // in_tdata: char_code [7:0], pos_row [12:8], pos_col [19:13], visible [20]
  input  logic [tcw_pkg::IN_DATA_W-1:0]  in_tdata,
  // in_tuser: opcode [2:0]
  input  logic [tcw_pkg::OPC_W-1:0]      in_tuser,
  // Results.
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // out_tdata: cursor_offset [10:0], read_char [18:11], read_fore [22:19],
  // read_back [26:23]
  output logic [tcw_pkg::OUT_DATA_W-1:0] out_tdata,
  // Configuration.
  input  logic                           cfg_psel,
  input  logic                           cfg_penable,
  input  logic                           cfg_pwrite,
  input  logic [tcw_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [tcw_pkg::CFG_DATA_W-1:0] cfg_pwdata,
  output logic [tcw_pkg::CFG_DATA_W-1:0] cfg_prdata,
  output logic                           cfg_pready
);

  localparam int Depth  = ROWS * COLS;
  localparam int AddrW  = $clog2(Depth);
  localparam int FullW0 = $clog2(63 * COLS + 256);
  localparam int FullW  = (FullW0 > tcw_pkg::OFS_W) ? FullW0 : tcw_pkg::OFS_W;
  localparam logic [tcw_pkg::OFS_W-1:0] HiddenPos = tcw_pkg::OFS_W'(Depth % 2048);

  function automatic logic [FullW-1:0] cell_index(
    logic [tcw_pkg::SCR_ROW_W-1:0] row,
    logic [tcw_pkg::SCR_COL_W-1:0] col
  );
    return FullW'(row) * FullW'(COLS) + FullW'(col);
  endfunction

  function automatic logic in_screen(
    logic [tcw_pkg::SCR_ROW_W-1:0] row,
    logic [tcw_pkg::SCR_COL_W-1:0] col
  );
    return (32'(row) < ROWS) && (32'(col) < COLS);
  endfunction

  // Request fields.
  logic [tcw_pkg::OPC_W-1:0]  in_opcode;
  logic [tcw_pkg::CHAR_W-1:0] in_char;
  logic [tcw_pkg::ROW_W-1:0]  in_row;
  logic [tcw_pkg::COL_W-1:0]  in_col;
  logic                       in_vis;

  assign in_opcode = in_tuser;
  assign in_char   = in_tdata[7:0];
  assign in_row    = in_tdata[12:8];
  assign in_col    = in_tdata[19:13];
  assign in_vis    = in_tdata[20];

  tcw_pkg::tcw_state_t state_r, state_nxt;

  logic [AddrW-1:0]              init_cnt_r, init_cnt_nxt;
  logic [tcw_pkg::ROW_W-1:0]     walk_row_r, walk_row_nxt;
  logic [tcw_pkg::COL_W-1:0]     walk_col_r, walk_col_nxt;
  logic [tcw_pkg::ROW_W-1:0]     print_row_r, print_row_nxt;
  logic [tcw_pkg::COL_W-1:0]     print_col_r, print_col_nxt;
  logic                          shown_r, shown_nxt;
  logic [tcw_pkg::OFS_W-1:0]     cursor_pos_r, cursor_pos_nxt;
  logic [tcw_pkg::OPC_W-1:0]     op_r, op_nxt;

  logic [tcw_pkg::ROW_W-1:0]     win_top_r, win_top_nxt;
  logic [tcw_pkg::COL_W-1:0]     win_left_r, win_left_nxt;
  logic [tcw_pkg::ROW_W-1:0]     win_height_r, win_height_nxt;
  logic [tcw_pkg::COL_W-1:0]     win_width_r, win_width_nxt;
  logic [tcw_pkg::CLR_W-1:0]     fore_r, fore_nxt;
  logic [tcw_pkg::CLR_W-1:0]     back_r, back_nxt;

  // Write stage in front of the RAM write port.
  logic                          wr_v_r, wr_v_nxt;
  logic [AddrW-1:0]              wr_addr_r, wr_addr_nxt;
  logic                          wr_use_rd_r, wr_use_rd_nxt;
  logic [tcw_pkg::CELL_W-1:0]    wr_const_r, wr_const_nxt;
  logic [tcw_pkg::CELL_W-1:0]    wr_data;

  // Read side.
  logic                          rd_en;
  logic [AddrW-1:0]              rd_addr;
  logic                          rd_ok_r, rd_ok_nxt;
  logic [tcw_pkg::CELL_W-1:0]    ram_q;
  logic [tcw_pkg::CELL_W-1:0]    rd_eff;
  logic                          fwd_v_r, fwd_v_nxt;
  logic [tcw_pkg::CELL_W-1:0]    fwd_d_r;

  // Output register and skid slot.
  logic                          out_v_r, out_v_nxt;
  tcw_pkg::tcw_result_t          out_d_r, out_d_nxt;
  logic                          skid_v_r, skid_v_nxt;
  tcw_pkg::tcw_result_t          skid_d_r, skid_d_nxt;
  logic                          push;
  tcw_pkg::tcw_result_t          push_d;
  logic                          pop;

  // Address calculation inputs.
  logic [tcw_pkg::SCR_ROW_W-1:0] dst_row, src_row, cur_row;
  logic [tcw_pkg::SCR_COL_W-1:0] dst_col, src_col, cur_col;
  logic [FullW-1:0]              dst_full, src_full, cur_full;
  logic                          dst_ok, src_ok;

  logic                          acc;
  logic                          cfg_we;
  logic [tcw_pkg::ROW_W-1:0]     eff_h, last_row;
  logic [tcw_pkg::COL_W-1:0]     eff_w, last_col;
  logic                          nl_scroll;
  logic [tcw_pkg::ROW_W-1:0]     nl_row;
  logic                          wrap;
  logic [tcw_pkg::CELL_W-1:0]    blank;

  assign acc       = in_tvalid && in_tready;
  assign in_tready = (state_r == tcw_pkg::ST_IDLE) && !skid_v_r;
  assign pop       = out_v_r && out_tready;
  assign out_tvalid = out_v_r;
  assign out_tdata = {(tcw_pkg::OUT_DATA_W - $bits(tcw_pkg::tcw_result_t))'(0), out_d_r};

  assign cfg_we     = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_pready = 1'b1;

  always_comb begin
    unique case (cfg_paddr[4:2])
      tcw_pkg::REG_WIN_TOP:    cfg_prdata = 32'(win_top_r);
      tcw_pkg::REG_WIN_LEFT:   cfg_prdata = 32'(win_left_r);
      tcw_pkg::REG_WIN_HEIGHT: cfg_prdata = 32'(win_height_r);
      tcw_pkg::REG_WIN_WIDTH:  cfg_prdata = 32'(win_width_r);
      tcw_pkg::REG_FORE:       cfg_prdata = 32'(fore_r);
      tcw_pkg::REG_BACK:       cfg_prdata = 32'(back_r);
      default:                 cfg_prdata = '0;
    endcase
  end

  // A zero height or width acts as one.
  assign eff_h    = (win_height_r == '0) ? tcw_pkg::ROW_W'(1) : win_height_r;
  assign eff_w    = (win_width_r == '0) ? tcw_pkg::COL_W'(1) : win_width_r;
  assign last_row = eff_h - tcw_pkg::ROW_W'(1);
  assign last_col = eff_w - tcw_pkg::COL_W'(1);
  assign blank    = {back_r, fore_r, tcw_pkg::CHAR_W'(0)};

  assign nl_scroll = ({1'b0, print_row_r} + tcw_pkg::SCR_ROW_W'(1)) >= {1'b0, eff_h};
  assign nl_row    = nl_scroll ? last_row : print_row_r + tcw_pkg::ROW_W'(1);
  assign wrap      = ({1'b0, print_col_r} + tcw_pkg::SCR_COL_W'(1)) >= {1'b0, eff_w};

  assign cur_row  = {1'b0, win_top_r} + {1'b0, print_row_r};
  assign cur_col  = {1'b0, win_left_r} + {1'b0, print_col_r};
  assign cur_full = cell_index(cur_row, cur_col);
  assign dst_full = cell_index(dst_row, dst_col);
  assign src_full = cell_index(src_row, src_col);
  assign dst_ok   = in_screen(dst_row, dst_col);
  assign src_ok   = in_screen(src_row, src_col);

  assign rd_eff  = fwd_v_r ? fwd_d_r : ram_q;
  assign wr_data = wr_use_rd_r ? (rd_ok_r ? rd_eff : '0) : wr_const_r;
  assign fwd_v_nxt = rd_en && wr_v_r && (rd_addr == wr_addr_r);

  always_comb begin
    state_nxt      = state_r;
    init_cnt_nxt   = init_cnt_r;
    walk_row_nxt   = walk_row_r;
    walk_col_nxt   = walk_col_r;
    print_row_nxt  = print_row_r;
    print_col_nxt  = print_col_r;
    shown_nxt      = shown_r;
    cursor_pos_nxt = cursor_pos_r;
    op_nxt         = op_r;
    win_top_nxt    = win_top_r;
    win_left_nxt   = win_left_r;
    win_height_nxt = win_height_r;
    win_width_nxt  = win_width_r;
    fore_nxt       = fore_r;
    back_nxt       = back_r;
    wr_v_nxt       = 1'b0;
    wr_addr_nxt    = dst_full[AddrW-1:0];
    wr_use_rd_nxt  = 1'b0;
    wr_const_nxt   = blank;
    rd_en          = 1'b0;
    rd_addr        = src_full[AddrW-1:0];
    rd_ok_nxt      = rd_ok_r;
    dst_row        = cur_row;
    dst_col        = cur_col;
    src_row        = {1'b0, in_row};
    src_col        = {1'b0, in_col};
    push           = 1'b0;
    push_d         = '0;

    if (cfg_we) begin
      unique case (cfg_paddr[4:2])
        tcw_pkg::REG_WIN_TOP:    win_top_nxt    = cfg_pwdata[tcw_pkg::ROW_W-1:0];
        tcw_pkg::REG_WIN_LEFT:   win_left_nxt   = cfg_pwdata[tcw_pkg::COL_W-1:0];
        tcw_pkg::REG_WIN_HEIGHT: win_height_nxt = cfg_pwdata[tcw_pkg::ROW_W-1:0];
        tcw_pkg::REG_WIN_WIDTH:  win_width_nxt  = cfg_pwdata[tcw_pkg::COL_W-1:0];
        tcw_pkg::REG_FORE:       fore_nxt       = cfg_pwdata[tcw_pkg::CLR_W-1:0];
        tcw_pkg::REG_BACK:       back_nxt       = cfg_pwdata[tcw_pkg::CLR_W-1:0];
        default: ;
      endcase
    end

    unique case (state_r)
      tcw_pkg::ST_INIT: begin
        wr_v_nxt     = 1'b1;
        wr_addr_nxt  = init_cnt_r;
        wr_const_nxt = '0;
        if (init_cnt_r == AddrW'(Depth - 1)) begin
          state_nxt = tcw_pkg::ST_IDLE;
        end else begin
          init_cnt_nxt = init_cnt_r + AddrW'(1);
        end
      end

      tcw_pkg::ST_IDLE: begin
        if (acc) begin
          op_nxt    = in_opcode;
          state_nxt = tcw_pkg::ST_DONE;
          unique case (in_opcode)
            tcw_pkg::OP_PUT_CHAR: begin
              if (in_char == tcw_pkg::CHAR_CR) begin
                print_col_nxt = '0;
              end else begin
                if (in_char != tcw_pkg::CHAR_LF) begin
                  // Any byte other than CR or LF is written at the caret, before the caret moves.
                  wr_v_nxt     = dst_ok;
                  wr_const_nxt = {back_r, fore_r, in_char};
                end
                if (in_char == tcw_pkg::CHAR_LF || wrap) begin
                  print_col_nxt = '0;
                  print_row_nxt = nl_row;
                  if (nl_scroll) begin
                    walk_col_nxt = '0;
                    if (last_row != '0) begin
                      walk_row_nxt = tcw_pkg::ROW_W'(1);
                      state_nxt    = tcw_pkg::ST_COPY;
                    end else begin
                      walk_row_nxt = last_row;
                      state_nxt    = tcw_pkg::ST_FILL;
                    end
                  end
                end else begin
                  print_col_nxt = print_col_r + tcw_pkg::COL_W'(1);
                end
              end
            end
            tcw_pkg::OP_SET_CARET: begin
              print_row_nxt = in_row;
              print_col_nxt = in_col;
            end
            tcw_pkg::OP_SET_VIS: begin
              shown_nxt = in_vis;
            end
            tcw_pkg::OP_CLEAR: begin
              walk_row_nxt = '0;
              walk_col_nxt = '0;
              state_nxt    = tcw_pkg::ST_FILL;
            end
            tcw_pkg::OP_READ_CELL: begin
              rd_en     = src_ok;
              rd_ok_nxt = src_ok;
            end
            default: ;
          endcase
        end
      end

      tcw_pkg::ST_COPY: begin
        // Read row r of the window now; its cell lands in row r-1 next cycle.
        src_row       = {1'b0, win_top_r} + {1'b0, walk_row_r};
        src_col       = {1'b0, win_left_r} + {1'b0, walk_col_r};
        dst_row       = src_row - tcw_pkg::SCR_ROW_W'(1);
        dst_col       = src_col;
        rd_en         = src_ok;
        rd_ok_nxt     = src_ok;
        wr_v_nxt      = dst_ok;
        wr_use_rd_nxt = 1'b1;
        if (walk_col_r == last_col) begin
          walk_col_nxt = '0;
          if (walk_row_r == last_row) begin
            state_nxt = tcw_pkg::ST_FILL;
          end else begin
            walk_row_nxt = walk_row_r + tcw_pkg::ROW_W'(1);
          end
        end else begin
          walk_col_nxt = walk_col_r + tcw_pkg::COL_W'(1);
        end
      end

      tcw_pkg::ST_FILL: begin
        dst_row  = {1'b0, win_top_r} + {1'b0, walk_row_r};
        dst_col  = {1'b0, win_left_r} + {1'b0, walk_col_r};
        wr_v_nxt = dst_ok;
        if (walk_col_r == last_col) begin
          walk_col_nxt = '0;
          if (walk_row_r == last_row) begin
            state_nxt = tcw_pkg::ST_DONE;
          end else begin
            walk_row_nxt = walk_row_r + tcw_pkg::ROW_W'(1);
          end
        end else begin
          walk_col_nxt = walk_col_r + tcw_pkg::COL_W'(1);
        end
      end

      tcw_pkg::ST_DONE: begin
        state_nxt = tcw_pkg::ST_IDLE;
        if (op_r == tcw_pkg::OP_PUT_CHAR || op_r == tcw_pkg::OP_SET_CARET) begin
          if (shown_r) begin
            cursor_pos_nxt = cur_full[tcw_pkg::OFS_W-1:0];
          end
        end else if (op_r == tcw_pkg::OP_SET_VIS) begin
          cursor_pos_nxt = shown_r ? cur_full[tcw_pkg::OFS_W-1:0] : HiddenPos;
        end
        push          = 1'b1;
        push_d.cursor = cursor_pos_nxt;
        if (op_r == tcw_pkg::OP_READ_CELL && rd_ok_r) begin
          push_d.chr  = rd_eff[7:0];
          push_d.fore = rd_eff[11:8];
          push_d.back = rd_eff[15:12];
        end
      end

      default: begin
        state_nxt = tcw_pkg::ST_IDLE;
      end
    endcase
  end

  // Output register with one skid slot behind it.
  always_comb begin
    out_v_nxt  = out_v_r;
    out_d_nxt  = out_d_r;
    skid_v_nxt = skid_v_r;
    skid_d_nxt = skid_d_r;
    if (pop) begin
      if (skid_v_r) begin
        out_d_nxt  = skid_d_r;
        skid_v_nxt = push;
        skid_d_nxt = push_d;
      end else begin
        out_v_nxt = push;
        out_d_nxt = push_d;
      end
    end else if (push) begin
      if (out_v_r) begin
        skid_v_nxt = 1'b1;
        skid_d_nxt = push_d;
      end else begin
        out_v_nxt = 1'b1;
        out_d_nxt = push_d;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tcw_pkg::ST_INIT;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      init_cnt_r   <= '0;
      walk_row_r   <= '0;
      walk_col_r   <= '0;
      print_row_r  <= '0;
      print_col_r  <= '0;
      shown_r      <= 1'b0;
      cursor_pos_r <= '0;
      op_r         <= tcw_pkg::OP_PUT_CHAR;
      win_top_r    <= tcw_pkg::ROW_W'(0);
      win_left_r   <= tcw_pkg::COL_W'(0);
      win_height_r <= tcw_pkg::ROW_W'(25);
      win_width_r  <= tcw_pkg::COL_W'(80);
      fore_r       <= tcw_pkg::CLR_W'(15);
      back_r       <= tcw_pkg::CLR_W'(0);
      wr_v_r       <= 1'b0;
      rd_ok_r      <= 1'b0;
      fwd_v_r      <= 1'b0;
      out_v_r      <= 1'b0;
      skid_v_r     <= 1'b0;
    end else begin
      init_cnt_r   <= init_cnt_nxt;
      walk_row_r   <= walk_row_nxt;
      walk_col_r   <= walk_col_nxt;
      print_row_r  <= print_row_nxt;
      print_col_r  <= print_col_nxt;
      shown_r      <= shown_nxt;
      cursor_pos_r <= cursor_pos_nxt;
      op_r         <= op_nxt;
      win_top_r    <= win_top_nxt;
      win_left_r   <= win_left_nxt;
      win_height_r <= win_height_nxt;
      win_width_r  <= win_width_nxt;
      fore_r       <= fore_nxt;
      back_r       <= back_nxt;
      wr_v_r       <= wr_v_nxt;
      rd_ok_r      <= rd_ok_nxt;
      fwd_v_r      <= fwd_v_nxt;
      out_v_r      <= out_v_nxt;
      skid_v_r     <= skid_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    wr_addr_r   <= wr_addr_nxt;
    wr_use_rd_r <= wr_use_rd_nxt;
    wr_const_r  <= wr_const_nxt;
    fwd_d_r     <= wr_data;
    out_d_r     <= out_d_nxt;
    skid_d_r    <= skid_d_nxt;
  end

  tcw_ram #(
    .WIDTH (tcw_pkg::CELL_W),
    .DEPTH (Depth)
  ) u_screen (
    .clk     (clk),
    .wr_en   (wr_v_r),
    .wr_addr (wr_addr_r),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (ram_q)
  );

  // Only one request is in flight, so its result always finds a free slot.
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == tcw_pkg::ST_DONE) |-> !skid_v_r)
    else $error("result pushed while the skid slot is full");

  assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("second request taken while one is in progress");

  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == tcw_pkg::ST_DONE) |=> out_tvalid)
    else $error("finished request produced no result");

  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == tcw_pkg::ST_COPY) |-> (win_height_r > tcw_pkg::ROW_W'(1)))
    else $error("scroll copy phase entered with a single-row window");

endmodule

[verif/tb_text_console_writer_core.sv]
// Self-checking testbench for text_console_writer_core: requests go in through the
// input stream, results are predicted by a behavioural console model and compared.
// Depends on tcw_pkg and the core RTL.
`timescale 1ns / 100ps

module tb_text_console_writer_core;

  localparam int ROWS = 25;
  localparam int COLS = 80;
  localparam int CYCLE_LIMIT = 1_500_000;
  localparam int REPORT_LIMIT = 10;

  typedef struct {
    logic [tcw_pkg::OPC_W-1:0]  opc;
    logic [tcw_pkg::CHAR_W-1:0] chr;
    logic [tcw_pkg::ROW_W-1:0]  row;
    logic [tcw_pkg::COL_W-1:0]  col;
    logic                       vis;
  } console_req_t;

  logic                           clk = 1'b0;
  logic                           rst_n = 1'b0;
  logic                           in_tvalid = 1'b0;
  logic                           in_tready;
  logic [tcw_pkg::IN_DATA_W-1:0]  in_tdata = '0;
  logic [tcw_pkg::OPC_W-1:0]      in_tuser = '0;
  logic                           out_tvalid;
  logic                           out_tready = 1'b0;
  logic [tcw_pkg::OUT_DATA_W-1:0] out_tdata;
  logic                           cfg_psel = 1'b0;
  logic                           cfg_penable = 1'b0;
  logic                           cfg_pwrite = 1'b0;
  logic [tcw_pkg::CFG_ADDR_W-1:0] cfg_paddr = '0;
  logic [tcw_pkg::CFG_DATA_W-1:0] cfg_pwdata = '0;
  logic [tcw_pkg::CFG_DATA_W-1:0] cfg_prdata;
  logic                           cfg_pready;

  text_console_writer_core #(
    .ROWS(ROWS),
    .COLS(COLS)
  ) u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  always #5 clk = ~clk;

  // Mirror of the console state.
  logic [tcw_pkg::CELL_W-1:0] screen_mirror [0:ROWS*COLS-1];
  logic [tcw_pkg::ROW_W-1:0]  print_row;
  logic [tcw_pkg::COL_W-1:0]  print_col;
  logic                       cursor_on;
  logic [tcw_pkg::OFS_W-1:0]  cursor_reg;
  logic [tcw_pkg::ROW_W-1:0]  win_top;
  logic [tcw_pkg::COL_W-1:0]  win_left;
  logic [tcw_pkg::ROW_W-1:0]  win_h;
  logic [tcw_pkg::COL_W-1:0]  win_w;
  logic [tcw_pkg::CLR_W-1:0]  fg_colour;
  logic [tcw_pkg::CLR_W-1:0]  bg_colour;

  console_req_t         request_queue[$];
  tcw_pkg::tcw_result_t due_results[$];
  console_req_t         cur_req;
  tcw_pkg::tcw_result_t got_res;
  tcw_pkg::tcw_result_t want_res;

  int unsigned idle_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned mismatch_count = 0;
  int unsigned requests_accepted = 0;
  int unsigned results_checked = 0;
  int unsigned scroll_count = 0;
  int unsigned clear_count = 0;
  int unsigned windows_used = 0;
  int unsigned cycle_count = 0;

  function automatic int unsigned eff_h();
    return (win_h == 0) ? 1 : win_h;
  endfunction

  function automatic int unsigned eff_w();
    return (win_w == 0) ? 1 : win_w;
  endfunction

  function automatic logic [tcw_pkg::CELL_W-1:0] blank_cell();
    return {bg_colour, fg_colour, 8'h00};
  endfunction

  // Cells outside the screen read as zero and swallow writes.
  function automatic logic [tcw_pkg::CELL_W-1:0] cell_at(int unsigned r, int unsigned c);
    if (r >= ROWS || c >= COLS) return '0;
    return screen_mirror[r*COLS + c];
  endfunction

  function automatic void cell_set(int unsigned r, int unsigned c,
                                   logic [tcw_pkg::CELL_W-1:0] v);
    if (r < ROWS && c < COLS) screen_mirror[r*COLS + c] = v;
  endfunction

  function automatic void place_cursor();
    int unsigned ofs;
    ofs = (int'(win_top) + int'(print_row)) * COLS + int'(win_left) + int'(print_col);
    cursor_reg = ofs[tcw_pkg::OFS_W-1:0];
  endfunction

  function automatic void scroll_window();
    int unsigned h, w, r, c;
    h = eff_h();
    w = eff_w();
    scroll_count++;
    for (r = 1; r < h; r++)
      for (c = 0; c < w; c++)
        cell_set(win_top + r - 1, win_left + c, cell_at(win_top + r, win_left + c));
    for (c = 0; c < w; c++)
      cell_set(win_top + h - 1, win_left + c, blank_cell());
  endfunction

  function automatic void advance_line();
    int unsigned h;
    h = eff_h();
    print_col = '0;
    if (print_row + 1 >= h) begin
      scroll_window();
      print_row = tcw_pkg::ROW_W'(h - 1);
    end else begin
      print_row = print_row + 1'b1;
    end
  endfunction

  function automatic void print_byte(logic [tcw_pkg::CHAR_W-1:0] ch);
    if (ch == tcw_pkg::CHAR_CR) begin
      print_col = '0;
    end else if (ch == tcw_pkg::CHAR_LF) begin
      advance_line();
    end else begin
      cell_set(int'(win_top) + int'(print_row), int'(win_left) + int'(print_col),
               {bg_colour, fg_colour, ch});
      if (print_col + 1 >= eff_w()) advance_line();
      else print_col = print_col + 1'b1;
    end
  endfunction

  function automatic void clear_window();
    int unsigned h, w, r, c;
    h = eff_h();
    w = eff_w();
    clear_count++;
    for (r = 0; r < h; r++)
      for (c = 0; c < w; c++)
        cell_set(win_top + r, win_left + c, blank_cell());
  endfunction

  function automatic tcw_pkg::tcw_result_t predict_console(console_req_t q);
    tcw_pkg::tcw_result_t res;
    logic [tcw_pkg::CELL_W-1:0] cell_val;
    cell_val = '0;
    case (q.opc)
      tcw_pkg::OP_PUT_CHAR: begin
        print_byte(q.chr);
        if (cursor_on) place_cursor();
      end
      tcw_pkg::OP_SET_CARET: begin
        print_row = q.row;
        print_col = q.col;
        if (cursor_on) place_cursor();
      end
      tcw_pkg::OP_SET_VIS: begin
        cursor_on = q.vis;
        if (q.vis) place_cursor();
        else cursor_reg = tcw_pkg::OFS_W'(ROWS * COLS);
      end
      tcw_pkg::OP_CLEAR: clear_window();
      tcw_pkg::OP_READ_CELL: cell_val = cell_at(q.row, q.col);
      default: ;
    endcase
    res.cursor = cursor_reg;
    res.chr    = cell_val[7:0];
    res.fore   = cell_val[11:8];
    res.back   = cell_val[15:12];
    return res;
  endfunction

  function automatic console_req_t make_req(logic [tcw_pkg::OPC_W-1:0] opc,
                                            logic [tcw_pkg::CHAR_W-1:0] chr,
                                            int unsigned row, int unsigned col, logic vis);
    console_req_t q;
    q.opc = opc;
    q.chr = chr;
    q.row = tcw_pkg::ROW_W'(row);
    q.col = tcw_pkg::COL_W'(col);
    q.vis = vis;
    return q;
  endfunction

  // Mostly text and line breaks; caret moves, window reads, cursor toggles, clears.
  function automatic console_req_t random_request();
    console_req_t q;
    int unsigned pick, h, w, r, c;
    h = eff_h();
    w = eff_w();
    q = make_req(tcw_pkg::OP_PUT_CHAR, tcw_pkg::CHAR_W'($urandom),
                 $urandom_range(0, ROWS-1), $urandom_range(0, COLS-1), 1'($urandom));
    pick = $urandom_range(0, 99);
    if (pick < 58) begin
      if ($urandom_range(0, 99) < 12) q.chr = tcw_pkg::CHAR_LF;
      else if ($urandom_range(0, 99) < 6) q.chr = tcw_pkg::CHAR_CR;
    end else if (pick < 68) begin
      q.opc = tcw_pkg::OP_SET_CARET;
      if ($urandom_range(0, 4) != 0) begin
        q.row = tcw_pkg::ROW_W'($urandom_range(0, h - 1));
        q.col = tcw_pkg::COL_W'($urandom_range(0, w - 1));
      end
    end else if (pick < 74) begin
      q.opc = tcw_pkg::OP_SET_VIS;
    end else if (pick < 76 && (h * w <= 400 || $urandom_range(0, 9) == 0)) begin
      q.opc = tcw_pkg::OP_CLEAR;
    end else if (pick < 99) begin
      q.opc = tcw_pkg::OP_READ_CELL;
      if ($urandom_range(0, 3) != 0) begin
        r = win_top + $urandom_range(0, h - 1);
        c = win_left + $urandom_range(0, w - 1);
        q.row = tcw_pkg::ROW_W'((r < ROWS) ? r : $urandom_range(0, ROWS-1));
        q.col = tcw_pkg::COL_W'((c < COLS) ? c : $urandom_range(0, COLS-1));
      end
    end else begin
      q.opc = tcw_pkg::OP_READ_CELL + tcw_pkg::OPC_W'($urandom_range(1, 3));
    end
    return q;
  endfunction

  // Request driver.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        due_results.push_back(predict_console(cur_req));
        requests_accepted++;
      end
      if (!in_tvalid || in_tready) begin
        if (request_queue.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
          cur_req = request_queue.pop_front();
          in_tdata <= {3'b000, cur_req.vis, cur_req.col, cur_req.row, cur_req.chr};
          in_tuser <= cur_req.opc;
          in_tvalid <= 1'b1;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Result monitor.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        got_res = tcw_pkg::tcw_result_t'(out_tdata[$bits(tcw_pkg::tcw_result_t)-1:0]);
        if (due_results.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_LIMIT)
            $display("Unexpected result %h with no request outstanding", out_tdata);
        end else begin
          want_res = due_results.pop_front();
          if (got_res.cursor !== want_res.cursor || got_res.chr !== want_res.chr ||
              got_res.fore !== want_res.fore || got_res.back !== want_res.back) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT)
              $display({"Result %0d: expected cursor %0d char %h fore %0d back %0d,",
                        " got cursor %0d char %h fore %0d back %0d"},
                       results_checked, want_res.cursor, want_res.chr, want_res.fore,
                       want_res.back, got_res.cursor, got_res.chr, got_res.fore,
                       got_res.back);
          end
          results_checked++;
        end
      end
      out_tready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timed out with %0d results outstanding", due_results.size());
      $display("FAIL");
      $finish;
    end
  end

  task automatic write_reg(input logic [2:0] idx,
                           input logic [tcw_pkg::CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    case (idx)
      tcw_pkg::REG_WIN_TOP:    win_top   = val[tcw_pkg::ROW_W-1:0];
      tcw_pkg::REG_WIN_LEFT:   win_left  = val[tcw_pkg::COL_W-1:0];
      tcw_pkg::REG_WIN_HEIGHT: win_h     = val[tcw_pkg::ROW_W-1:0];
      tcw_pkg::REG_WIN_WIDTH:  win_w     = val[tcw_pkg::COL_W-1:0];
      tcw_pkg::REG_FORE:       fg_colour = val[tcw_pkg::CLR_W-1:0];
      tcw_pkg::REG_BACK:       bg_colour = val[tcw_pkg::CLR_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_window(int unsigned top, int unsigned left, int unsigned h,
                            int unsigned w, int unsigned fore, int unsigned back);
    write_reg(tcw_pkg::REG_WIN_TOP, top);
    write_reg(tcw_pkg::REG_WIN_LEFT, left);
    write_reg(tcw_pkg::REG_WIN_HEIGHT, h);
    write_reg(tcw_pkg::REG_WIN_WIDTH, w);
    write_reg(tcw_pkg::REG_FORE, fore);
    write_reg(tcw_pkg::REG_BACK, back);
    windows_used++;
  endtask

  // Registers only change once every outstanding request has produced its result.
  // The check runs on the falling edge so that it sees the driver's settled state.
  task automatic wait_idle();
    @(negedge clk);
    while (request_queue.size() != 0 || in_tvalid || due_results.size() != 0)
      @(negedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic run_random(int unsigned n, int unsigned send_idle, int unsigned recv_stall);
    idle_pct  = send_idle;
    stall_pct = recv_stall;
    repeat (n) request_queue.push_back(random_request());
    wait_idle();
  endtask

  initial begin
    for (int i = 0; i < ROWS*COLS; i++) screen_mirror[i] = '0;
    print_row  = '0;
    print_col  = '0;
    cursor_on  = 1'b0;
    cursor_reg = '0;
    win_top    = '0;
    win_left   = '0;
    win_h      = tcw_pkg::ROW_W'(25);
    win_w      = tcw_pkg::COL_W'(80);
    fg_colour  = 4'd15;
    bg_colour  = 4'd0;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Reset window: printing, wrap at the bottom right corner and the scroll it causes.
    windows_used++;
    request_queue.push_back(make_req(tcw_pkg::OP_READ_CELL, 8'h00, 0, 0, 1'b0));
    request_queue.push_back(make_req(tcw_pkg::OP_READ_CELL, 8'h00, ROWS-1, COLS-1, 1'b0));
    request_queue.push_back(make_req(tcw_pkg::OP_SET_VIS, 8'h00, 0, 0, 1'b1));
    request_queue.push_back(make_req(tcw_pkg::OP_PUT_CHAR, 8'h41, 0, 0, 1'b0));
    request_queue.push_back(make_req(tcw_pkg::OP_PUT_CHAR, 8'hFF, 0, 0, 1'b0));
    request_queue.push_back(make_req(tcw_pkg::OP_PUT_CHAR, 8'h00, 0, 0, 1'b0));
    request_queue.push_back(make_req(tcw_pkg::OP_PUT_CHAR, tcw_pkg::CHAR_CR, 0, 0, 1'b0));
    request_queue.push_back(make_req(tcw_pkg::OP_PUT_CHAR, tcw_pkg::CHAR_LF, 0, 0, 1'b0));
    request_queue.push_back(make_req(tcw_pkg::OP_READ_CELL, 8'h00, 0, 1, 1'b0));
    request_queue.push_back(make_req(tcw_pkg::OP_SET_CARET, 8'h00, 24, 79, 1'b0));
    request_queue.push_back(make_req(tcw_pkg::OP_PUT_CHAR, 8'h5A, 0, 0, 1'b0));
    request_queue.push_back(make_req(tcw_pkg::OP_READ_CELL, 8'h00, 23, 79, 1'b0));
    request_queue.push_back(make_req(tcw_pkg::OP_READ_CELL, 8'h00, 0, 0, 1'b0));
    request_queue.push_back(make_req(tcw_pkg::OP_SET_VIS, 8'h00, 0, 0, 1'b0));
    wait_idle();

    // Zero height and width at the screen corner: the caret sits beyond the window,
    // writes fall off the screen and the cursor offset overflows its 11 bits.
    set_window(24, 79, 0, 0, 0, 15);
    request_queue.push_back(make_req(tcw_pkg::OP_SET_VIS, 8'h00, 0, 0, 1'b1));
    request_queue.push_back(make_req(tcw_pkg::OP_SET_CARET, 8'h00, 24, 79, 1'b0));
    request_queue.push_back(make_req(tcw_pkg::OP_PUT_CHAR, 8'h7E, 0, 0, 1'b0));
    request_queue.push_back(make_req(tcw_pkg::OP_READ_CELL, 8'h00, 24, 79, 1'b0));
    request_queue.push_back(make_req(tcw_pkg::OP_PUT_CHAR, tcw_pkg::CHAR_LF, 0, 0, 1'b0));
    request_queue.push_back(make_req(tcw_pkg::OP_PUT_CHAR, tcw_pkg::CHAR_CR, 0, 0, 1'b0));
    request_queue.push_back(make_req(tcw_pkg::OP_CLEAR, 8'h00, 0, 0, 1'b0));
    for (int k = 1; k <= 3; k++)
      request_queue.push_back(make_req(tcw_pkg::OP_READ_CELL + tcw_pkg::OPC_W'(k),
                                       8'($urandom), $urandom_range(0, ROWS-1),
                                       $urandom_range(0, COLS-1), 1'($urandom)));
    request_queue.push_back(make_req(tcw_pkg::OP_READ_CELL, 8'h00, 24, 79, 1'b0));
    wait_idle();

    set_window(3, 5, 4, 10, 2, 9);
    run_random(300, 0, 0);
    // Window hanging below the screen.
    set_window(24, 0, 25, 3, 0, 15);
    run_random(250, 66, 0);
    set_window(0, 0, 25, 80, 15, 0);
    run_random(150, 0, 66);
    // Window hanging off the right edge.
    set_window(10, 70, 6, 20, 7, 1);
    run_random(250, 20, 20);
    set_window(0, 79, 1, 80, 12, 3);
    run_random(200, 0, 0);
    set_window(20, 40, 1, 1, 15, 15);
    run_random(200, 66, 0);
    set_window(12, 30, 13, 50, 5, 10);
    run_random(200, 0, 66);

    repeat (20) @(posedge clk);
    $display("Checked %0d results from %0d requests over %0d window settings.",
             results_checked, requests_accepted, windows_used);
    $display("Predicted %0d window scrolls and %0d window clears; %0d mismatches.",
             scroll_count, clear_count, mismatch_count);
    if (mismatch_count == 0 && due_results.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
